[hdl/lts_pkg.sv]
package lts_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ANS_STORED  = 2'd0,
    ANS_DROPPED = 2'd1,
    ANS_QUERY   = 2'd2,
    ANS_NONE    = 2'd3
  } answer_e;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_TAG   = 2'd1,
    PH_SKIP  = 2'd2,
    PH_UNUSED = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STAMP_A,
    ST_STAMP_B,
    ST_SEARCH,
    ST_SEARCH_WAIT,
    ST_SEARCH_CMP,
    ST_SEARCH_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  text_byte;
    logic        last_byte;
    logic signed [31:0] query_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  answer_kind;
    logic [7:0]  entry_index;
    logic signed [31:0] stamp_ms;
    logic        found;
  } out_item_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

[hdl/lrc_timestamp_table_search.sv]
// Timed-lyric time-stamp table. Give a command by raising start_i while busy_o is low; the
// item transfers on that edge. A text byte is taken without leaving ST_IDLE, except a
// closing ']' of a usable tag: the products are formed in the accepting cycle, a partial
// sum follows in ST_STAMP_A, and ST_STAMP_B forms the stamp and writes the table.
// A time query runs from the accepting cycle through ST_SEARCH, ST_SEARCH_WAIT and
// ST_SEARCH_CMP for every probe of the binary search (set up the probe, one read of the
// single-port stamp memory with registered read data, one compare), then a final check
// in ST_SEARCH that fetches the selected entry, and ST_SEARCH_DONE forms the answer.
// A clear stays in ST_IDLE. Each result appears on result_o for exactly one cycle with
// valid_o high; the receiver cannot stall it, so it must take every transfer as it comes.
module lrc_timestamp_table_search (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  lts_pkg::in_item_t     item_i,
  output logic                  busy_o,
  output logic                  valid_o,
  output lts_pkg::out_item_t    result_o
);
  import lts_pkg::*;

  // Stamp memory: one address per cycle for both the write and the read, registered read data.
  logic [31:0] mem_q [TableDepth];
  logic [31:0] rdata_q;
  logic        mem_we;
  logic [IdxW-1:0] mem_addr;
  logic [31:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  phase_e phase_q, phase_d;
  logic [31:0] min_q, min_d, sec_q, sec_d, frac_q, frac_d;
  logic [2:0]  flen_q, flen_d;
  logic        f_nonempty_q, f_colon_q, f_dot_q, f_dotvalid_q, f_neg_q;
  logic        f_nonempty_d, f_colon_d, f_dot_d, f_dotvalid_d, f_neg_d;
  logic [1:0]  stage_q, stage_d;
  logic        finished_q, finished_d;
  // Search bounds count from one, so that an empty range never needs a negative bound.
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CntW:0]   best_q, best_d;
  logic signed [31:0] qry_q, qry_d;
  logic [31:0] pa_q, pa_d, pb_q, pb_d, pc_q, pc_d;
  logic        valid_q, valid_d;
  out_item_t   res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      phase_q <= PH_START;
      min_q <= '0; sec_q <= '0; frac_q <= '0; flen_q <= '0;
      f_nonempty_q <= 1'b0; f_colon_q <= 1'b0; f_dot_q <= 1'b0;
      f_dotvalid_q <= 1'b0; f_neg_q <= 1'b0; stage_q <= '0;
      finished_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      phase_q <= phase_d;
      min_q <= min_d; sec_q <= sec_d; frac_q <= frac_d; flen_q <= flen_d;
      f_nonempty_q <= f_nonempty_d; f_colon_q <= f_colon_d; f_dot_q <= f_dot_d;
      f_dotvalid_q <= f_dotvalid_d; f_neg_q <= f_neg_d; stage_q <= stage_d;
      finished_q <= finished_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d; best_q <= best_d;
    qry_q <= qry_d; pa_q <= pa_d; pb_q <= pb_d; pc_q <= pc_d;
    res_q <= res_d;
  end

  logic [7:0] c;
  logic       digit, take;
  logic [31:0] acc, acc_new;
  logic [CntW:0] span;

  always_comb begin
    state_d = state_q; count_d = count_q; phase_d = phase_q;
    min_d = min_q; sec_d = sec_q; frac_d = frac_q; flen_d = flen_q;
    f_nonempty_d = f_nonempty_q; f_colon_d = f_colon_q; f_dot_d = f_dot_q;
    f_dotvalid_d = f_dotvalid_q; f_neg_d = f_neg_q; stage_d = stage_q;
    finished_d = finished_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q; best_d = best_q; qry_d = qry_q;
    pa_d = pa_q; pb_d = pb_q; pc_d = pc_q;
    valid_d = 1'b0; res_d = res_q;
    mem_we = 1'b0; mem_addr = mid_q[IdxW-1:0]; mem_wdata = pa_q + pb_q + pc_q;
    c = item_i.text_byte;
    digit = (c >= 8'd48) && (c <= 8'd57);
    take = 1'b0;
    acc = f_dotvalid_q ? frac_q : (f_colon_q ? sec_q : min_q);
    acc_new = acc;
    span = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (item_i.kind)
            KIND_CLEAR: begin
              count_d = '0; finished_d = 1'b0; phase_d = PH_START;
              min_d = '0; sec_d = '0; frac_d = '0; flen_d = '0;
              f_nonempty_d = 1'b0; f_colon_d = 1'b0; f_dot_d = 1'b0;
              f_dotvalid_d = 1'b0; f_neg_d = 1'b0; stage_d = '0;
            end
            KIND_BYTE: begin
              if (!finished_q) begin
                if (c == 8'd0) begin
                  finished_d = 1'b1;
                end else begin
                  if (item_i.last_byte) finished_d = 1'b1;
                  if (c == 8'd10) begin
                    phase_d = PH_START;
                    min_d = '0; sec_d = '0; frac_d = '0; flen_d = '0;
                    f_nonempty_d = 1'b0; f_colon_d = 1'b0; f_dot_d = 1'b0;
                    f_dotvalid_d = 1'b0; f_neg_d = 1'b0; stage_d = '0;
                  end else if (phase_q == PH_START) begin
                    if (c == 8'd91) begin
                      phase_d = PH_TAG;
                      min_d = '0; sec_d = '0; frac_d = '0; flen_d = '0;
                      f_nonempty_d = 1'b0; f_colon_d = 1'b0; f_dot_d = 1'b0;
                      f_dotvalid_d = 1'b0; f_neg_d = 1'b0; stage_d = '0;
                    end else if (!is_space(c)) begin
                      phase_d = PH_SKIP;
                    end
                  end else if (phase_q == PH_TAG) begin
                    if (c == 8'd93) begin
                      phase_d = PH_SKIP;
                      if (f_colon_q) begin
                        // Partial products are registered before the sum.
                        pa_d = min_q * 32'd60000;
                        pb_d = sec_q * 32'd1000;
                        pc_d = !f_dotvalid_q ? 32'd0 :
                               (flen_q == 3'd2) ? (frac_q << 3) + (frac_q << 1) :
                               (flen_q == 3'd3) ? frac_q : 32'd0;
                        state_d = ST_STAMP_A;
                      end
                    end else begin
                      // Number scanner, atol style.
                      case (stage_q)
                        2'd0: begin
                          if (!is_space(c)) begin
                            if (c == 8'd43 || c == 8'd45) begin
                              if (c == 8'd45) f_neg_d = 1'b1;
                              stage_d = 2'd1;
                            end else if (digit) begin
                              take = 1'b1; stage_d = 2'd1;
                            end else begin
                              stage_d = 2'd2;
                            end
                          end
                        end
                        2'd1: begin
                          if (digit) take = 1'b1;
                          else stage_d = 2'd2;
                        end
                        default: ;
                      endcase
                      if (take) begin
                        acc_new = f_neg_d ?
                          (acc << 3) + (acc << 1) - {28'd0, c[3:0]} :
                          (acc << 3) + (acc << 1) + {28'd0, c[3:0]};
                        if (f_dotvalid_q) frac_d = acc_new;
                        else if (f_colon_q) sec_d = acc_new;
                        else min_d = acc_new;
                      end
                      if (f_dotvalid_q && flen_q < 3'd7) flen_d = flen_q + 3'd1;
                      f_nonempty_d = 1'b1;
                      if (c == 8'd58 && !f_colon_q) begin
                        f_colon_d = 1'b1;
                        if (!f_nonempty_q) begin
                          phase_d = PH_SKIP;
                        end else if (!f_dotvalid_q) begin
                          f_neg_d = 1'b0; stage_d = '0;
                        end
                      end else if (c == 8'd46 && !f_dot_q) begin
                        f_dot_d = 1'b1;
                        if (f_nonempty_q) begin
                          f_dotvalid_d = 1'b1; flen_d = '0;
                          f_neg_d = 1'b0; stage_d = '0;
                        end
                      end
                    end
                  end
                end
              end
            end
            KIND_QUERY: begin
              qry_d = item_i.query_ms;
              lo_d = CntW'(1);
              hi_d = count_q;
              best_d = '0;
              state_d = ST_SEARCH;
            end
            default: ;
          endcase
        end
      end
      ST_STAMP_A: begin
        pa_d = pa_q + pb_q;
        pb_d = '0;
        state_d = ST_STAMP_B;
      end
      ST_STAMP_B: begin
        res_d.stamp_ms = pa_q + pc_q;
        res_d.found = 1'b0;
        valid_d = 1'b1;
        state_d = ST_IDLE;
        if (count_q < CntW'(TableDepth)) begin
          mem_we = 1'b1;
          mem_addr = count_q[IdxW-1:0];
          mem_wdata = pa_q + pc_q;
          res_d.answer_kind = ANS_STORED;
          res_d.entry_index = 8'(count_q);
          count_d = count_q + CntW'(1);
        end else begin
          res_d.answer_kind = ANS_DROPPED;
          res_d.entry_index = '0;
        end
      end
      ST_SEARCH: begin
        if (lo_q > hi_q) begin
          state_d = ST_SEARCH_DONE;
          mem_addr = IdxW'(best_q - 1'b1);
        end else begin
          span = {1'b0, lo_q} + {1'b0, hi_q};
          mid_d = span[CntW:1];
          state_d = ST_SEARCH_WAIT;
        end
      end
      ST_SEARCH_WAIT: begin
        mem_addr = IdxW'(mid_q - CntW'(1));
        state_d = ST_SEARCH_CMP;
      end
      ST_SEARCH_CMP: begin
        if ($signed(rdata_q) <= qry_q) begin
          best_d = {1'b0, mid_q};
          lo_d = mid_q + CntW'(1);
        end else begin
          hi_d = mid_q - CntW'(1);
        end
        state_d = ST_SEARCH;
      end
      ST_SEARCH_DONE: begin
        valid_d = 1'b1;
        res_d.answer_kind = ANS_QUERY;
        if (best_q != '0) begin
          res_d.found = 1'b1;
          res_d.entry_index = 8'(best_q - 1'b1);
          res_d.stamp_ms = rdata_q;
        end else begin
          res_d.found = 1'b0;
          res_d.entry_index = '0;
          res_d.stamp_ms = '0;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign result_o = res_q;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth)) else $error("entry count beyond table depth");
  a_no_write_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH_CMP) |-> !mem_we) else $error("write during search");
  a_stamp_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STAMP_B) |=> valid_o) else $error("stamp result missing");
  a_found_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.found) |-> (result_o.answer_kind == ANS_QUERY))
    else $error("found set on line result");
`endif

endmodule

[sim/tb_lrc_timestamp_table_search.sv]
`timescale 1ns / 100ps

module tb_lrc_timestamp_table_search;
  import lts_pkg::*;

  // Generous bound: every transfer at its slowest (a full-table query) plus the longest
  // sender gap, for some five hundred transfers and the drains, taken several times over.
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned Depth = TableDepth;

  // Predictor of the stamp table and the line parser, together with the queue of
  // results still owed by the block.
  class lyric_table_board;
    bit [31:0] stamps [Depth];
    int unsigned count;
    phase_e phase;
    bit [31:0] minutes, seconds, frac;
    bit [2:0] frac_len;
    bit nonempty, colon, dot, dot_ok, neg;
    bit [1:0] num_stage;
    bit text_done;
    out_item_t owed_q [$];
    int errors;

    function new();
      count = 0;
      text_done = 0;
      errors = 0;
      reset_line();
    endfunction

    function void reset_line();
      phase = PH_START;
      minutes = '0;
      seconds = '0;
      frac = '0;
      frac_len = '0;
      {nonempty, colon, dot, dot_ok, neg} = '0;
      num_stage = '0;
    endfunction

    function bit blank(bit [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void feed_number(bit [7:0] c);
      bit digit;
      bit take;
      bit [31:0] d;
      digit = c >= "0" && c <= "9";
      take = 0;
      d = 32'(c) - 32'd48;
      if (num_stage == 2'd0) begin
        if (blank(c)) return;
        if (c == "+" || c == "-") begin
          if (c == "-") neg = 1;
          num_stage = 2'd1;
        end else if (digit) begin
          take = 1;
          num_stage = 2'd1;
        end else begin
          num_stage = 2'd2;
        end
      end else if (num_stage == 2'd1) begin
        if (digit) take = 1;
        else num_stage = 2'd2;
      end
      if (take) begin
        if (dot_ok) frac = neg ? frac * 10 - d : frac * 10 + d;
        else if (colon) seconds = neg ? seconds * 10 - d : seconds * 10 + d;
        else minutes = neg ? minutes * 10 - d : minutes * 10 + d;
      end
    endfunction

    function void close_tag();
      bit [31:0] ms;
      out_item_t r;
      phase = PH_SKIP;
      if (!colon) return;
      ms = '0;
      if (dot_ok) begin
        if (frac_len == 3'd2) ms = frac * 10;
        else if (frac_len == 3'd3) ms = frac;
      end
      r.stamp_ms = minutes * 60000 + seconds * 1000 + ms;
      r.found = 1'b0;
      if (count < Depth) begin
        stamps[count] = r.stamp_ms;
        r.answer_kind = ANS_STORED;
        r.entry_index = count[7:0];
        count++;
      end else begin
        r.answer_kind = ANS_DROPPED;
        r.entry_index = '0;
      end
      owed_q = {owed_q, r};
    endfunction

    function void take_byte(bit [7:0] c);
      if (c == 8'd10) begin
        reset_line();
        return;
      end
      if (phase == PH_START) begin
        if (c == "[") begin
          reset_line();
          phase = PH_TAG;
        end else if (!blank(c)) begin
          phase = PH_SKIP;
        end
        return;
      end
      if (phase != PH_TAG) return;
      if (c == "]") begin
        close_tag();
        return;
      end
      feed_number(c);
      if (dot_ok && frac_len < 3'd7) frac_len++;
      if (c == ":" && !colon) begin
        colon = 1;
        if (!nonempty) begin
          phase = PH_SKIP;
          return;
        end
        if (!dot_ok) begin
          neg = 0;
          num_stage = 2'd0;
        end
      end else if (c == "." && !dot) begin
        dot = 1;
        if (nonempty) begin
          dot_ok = 1;
          frac_len = '0;
          neg = 0;
          num_stage = 2'd0;
        end
      end
      nonempty = 1;
    endfunction

    function void search(bit signed [31:0] t);
      int lo, hi, mid, hit;
      out_item_t r;
      lo = 0;
      hi = int'(count) - 1;
      hit = -1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if ($signed(stamps[mid]) <= t) begin
          hit = mid;
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
      r.answer_kind = ANS_QUERY;
      if (hit >= 0) begin
        r.entry_index = hit[7:0];
        r.stamp_ms = stamps[hit];
        r.found = 1'b1;
      end else begin
        r.entry_index = '0;
        r.stamp_ms = '0;
        r.found = 1'b0;
      end
      owed_q = {owed_q, r};
    endfunction

    function void note_input(in_item_t it);
      case (kind_e'(it.kind))
        KIND_CLEAR: begin
          count = 0;
          text_done = 0;
          reset_line();
        end
        KIND_BYTE: begin
          if (!text_done) begin
            if (it.text_byte == 8'd0) begin
              text_done = 1;
            end else begin
              take_byte(it.text_byte);
              if (it.last_byte) text_done = 1;
            end
          end
        end
        KIND_QUERY: search(it.query_ms);
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result: kind %0d index %0d stamp %0d found %0d",
                   got.answer_kind, got.entry_index, got.stamp_ms, got.found);
        return;
      end
      want = owed_q.pop_front();
      if (got.answer_kind !== want.answer_kind || got.entry_index !== want.entry_index ||
          got.stamp_ms !== want.stamp_ms || got.found !== want.found) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected kind %0d index %0d stamp %0d found %0d, got %0d %0d %0d %0d",
                   want.answer_kind, want.entry_index, want.stamp_ms, want.found,
                   got.answer_kind, got.entry_index, got.stamp_ms, got.found);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  in_item_t  item_i = '0;
  logic      busy_o;
  logic      valid_o;
  out_item_t result_o;

  lyric_table_board board = new();
  int unsigned transfers = 0;
  int unsigned cycles = 0;
  bit idling = 1'b1;

  lrc_timestamp_table_search dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Monitor. Results are checked before the new transfer is noted, since a result on the
  // ports always belongs to an earlier transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) board.check_result(result_o);
      if (start_i && !busy_o) begin
        board.note_input(item_i);
        transfers++;
      end
    end
  end

  // Presents one item from a falling edge and holds it until the transfer happens. While
  // idling is enabled, a random burst of gap cycles may come first.
  task automatic send(in_item_t it);
    int unsigned seen;
    if (idling && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    item_i <= it;
    start_i <= 1'b1;
    seen = transfers;
    do @(negedge clk_i); while (transfers == seen);
  endtask

  task automatic send_byte(bit [7:0] c, bit last = 1'b0);
    in_item_t it;
    it.kind = KIND_BYTE;
    it.text_byte = c;
    it.last_byte = last;
    it.query_ms = $urandom;
    send(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_query(bit [31:0] t);
    in_item_t it;
    it.kind = KIND_QUERY;
    it.text_byte = 8'($urandom);
    it.last_byte = 1'($urandom);
    it.query_ms = t;
    send(it);
  endtask

  task automatic send_clear();
    in_item_t it;
    it.kind = KIND_CLEAR;
    it.text_byte = 8'($urandom);
    it.last_byte = 1'($urandom);
    it.query_ms = $urandom;
    send(it);
  endtask

  // The sender holds off until the block has delivered everything it owes.
  task automatic drain();
    start_i <= 1'b0;
    while (board.owed_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // One number field of a tag: an optional blank and sign, then digits. Now and then the
  // digit run is long enough for the 32-bit accumulator to wrap.
  function automatic string number_field();
    string s;
    int n;
    s = "";
    if ($urandom_range(0, 7) == 0) s = " ";
    case ($urandom_range(0, 9))
      0: s = {s, "-"};
      1: s = {s, "+"};
      default: ;
    endcase
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
    return s;
  endfunction

  // A lyric line, mostly well formed, sometimes malformed or holding a stray byte.
  task automatic send_line();
    string s;
    int pos;
    s = ($urandom_range(0, 5) == 0) ? " \t" : "";
    s = {s, "["};
    if ($urandom_range(0, 9) == 0) s = {s, "."};
    s = {s, number_field()};
    if ($urandom_range(0, 11) != 0) s = {s, ":"};
    if ($urandom_range(0, 9) != 0) s = {s, number_field()};
    if ($urandom_range(0, 2) != 0) begin
      s = {s, "."};
      repeat ($urandom_range(0, 4)) s = {s, string'(8'($urandom_range(48, 57)))};
    end
    if ($urandom_range(0, 11) != 0) s = {s, "]"};
    if ($urandom_range(0, 1) != 0) s = {s, "la la"};
    if ($urandom_range(0, 7) == 0) begin
      pos = $urandom_range(0, s.len() - 1);
      s[pos] = 8'($urandom_range(1, 255));
    end
    send_text(s);
    send_byte(8'd10, $urandom_range(0, 30) == 0);
  endtask

  task automatic random_query();
    bit [31:0] t;
    if (board.count != 0 && $urandom_range(0, 1) == 0) begin
      t = board.stamps[$urandom_range(0, board.count - 1)];
      t = t + $urandom_range(0, 2) - 1;
    end else begin
      t = $urandom;
    end
    send_query(t);
  endtask

  task automatic random_traffic(int unsigned quota);
    int unsigned stop_at;
    in_item_t it;
    stop_at = transfers + quota;
    while (transfers < stop_at) begin
      case ($urandom_range(0, 99)) inside
        [0:59]: send_line();
        [60:87]: random_query();
        [88:90]: send_clear();
        [91:94]: begin
          it.text_byte = 8'($urandom);
          it.last_byte = 1'($urandom);
          it.query_ms = $urandom;
          it.kind = KIND_NONE;
          send(it);
        end
        default: begin
          // The text ends early; later bytes must be ignored until a clear.
          if ($urandom_range(0, 1) != 0) send_byte(8'd0);
          else send_byte(8'($urandom_range(1, 255)), 1'b1);
          send_text("[1:2]\n");
          random_query();
          send_clear();
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: the parser's corner cases and the extreme query times.
    send_query(32'h8000_0000);
    send_text("[01:02.34]\n");
    send_text(" [-1:+2.345]\n");
    send_text("[.5:3][.7\n");
    send_text("[1.5:2]\n");
    send_text("[:12]\n[12]\nx[1:1]\n[3:4.1]\n[3:4.1234]\n");
    send_query(32'h7FFF_FFFF);
    send_query(32'd62000);
    send_byte(8'hFF);
    send_byte(8'd10, 1'b1);
    send_text("[5:5]\n");
    send_clear();
    send_text("[2:0]\n");
    send_byte(8'd0);
    send_text("[3:0]\n");
    send_query(32'd0);
    send_clear();
    drain();

    random_traffic(150);
    drain();

    // A run of ascending stamps, so that the search meets a sorted table.
    send_clear();
    for (int i = 0; i < 16; i++)
      send_text($sformatf("[%0d:%0d.%02d]\n", i / 2, (i % 2) * 30, i % 100));
    repeat (8) random_query();
    send_query(32'h8000_0000);
    send_query(32'h7FFF_FFFF);
    send_clear();

    // Last part without sender gaps.
    idling = 1'b0;
    random_traffic(50);
    start_i <= 1'b0;

    while (board.owed_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (board.errors == 0 && board.owed_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lts_pkg.sv
hdl/lrc_timestamp_table_search.sv
sim/tb_lrc_timestamp_table_search.sv
